@@ hdl/plct_pkg.sv @@
`default_nettype none

package plct_pkg;

   // Table geometry and field widths
   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = 4;
   localparam int CNT_W      = 5;
   localparam int POS_W      = 16;
   localparam int CH_W       = 8;
   localparam int COL_W      = 4 * CH_W;
   localparam int NUM_W      = CH_W + POS_W;
   localparam int REM_W      = NUM_W + 1;
   localparam int STEP_W     = 3;

   // Stream word widths
   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 64;

   // Command codes
   localparam logic [2:0] CMD_SAMPLE  = 3'd0;
   localparam logic [2:0] CMD_ADD     = 3'd1;
   localparam logic [2:0] CMD_REMOVE  = 3'd2;
   localparam logic [2:0] CMD_SET_POS = 3'd3;
   localparam logic [2:0] CMD_SET_COL = 3'd4;
   localparam logic [2:0] CMD_READ    = 3'd5;

   // Per-cell update operation
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_FROM_LEFT,
      OP_FROM_RIGHT,
      OP_WRITE_POS,
      OP_WRITE_COL,
      OP_WRITE_BOTH,
      OP_CLEAR
   } cell_op_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLAGS,
      ST_LOCATE,
      ST_PREP,
      ST_MULT,
      ST_INIT,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // Control of the per-channel interpolation units
   typedef struct packed {
      logic mul;
      logic init;
      logic step;
   } lerp_ctrl_type;

   // Power-up contents: point 0 at zero, transparent black; point 1 at 0xFFFF, opaque white
   function automatic logic [POS_W-1:0] init_pos(input int i);
      init_pos = (i == 1) ? {POS_W{1'b1}} : '0;
   endfunction

   function automatic logic [COL_W-1:0] init_col(input int i);
      init_col = (i == 1) ? {COL_W{1'b1}} : '0;
   endfunction

endpackage

`default_nettype wire

@@ hdl/piecewise_linear_color_transfer.sv @@
`default_nettype none
// Piecewise-linear color transfer table with up to sixteen control points.
// Input words arrive on the req_ stream: tuser carries the command (sample,
// add, remove, set position, set color, read point), tdata the position,
// point index and RGBA color. Every command returns exactly one word on the
// rsp_ stream with the color, read position, insert index, ok flag and the
// point count after the command.
// The points sit in a row of cells; add and remove shift the whole row by
// one cell at once, and each cell compares its position against the probe
// in parallel. A sample then clamps, forms the weighted sums in a multiply
// state and runs four 8-step restoring dividers side by side.
// The block takes one word at a time, so a new word is accepted at the
// earliest in the cycle after the previous result is loaded into the output
// register. Reset restores two points: position 0 transparent black and
// position 0xFFFF opaque white. A stalled receiver holds the result in the
// output register; the next word is still accepted and worked on, and waits
// before loading its result until the register is free.

module piecewise_linear_color_transfer
   import plct_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // [15:0] position, [19:16] point_index, [27:20] red_in, [35:28] green_in,
   // [43:36] blue_in, [51:44] alpha_in, [55:52] zero
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,
   // [2:0] command
   input  wire logic [REQ_TUSER_W-1:0]  req_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [31:24] alpha_out,
   // [47:32] position_out, [51:48] index_out, [52] ok, [57:53] point_count,
   // [63:58] zero
   output logic      [RSP_TDATA_W-1:0]  rsp_tdata
);

   state_type state_ff, state_in;

   // Latched command word
   logic [2:0]        cmd_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [COL_W-1:0]  col_ff;

   logic [CNT_W-1:0]  count_ff;
   logic [MAX_POINTS-1:0] gt_ff;

   // Cell row
   logic [POS_W-1:0]  cell_pos   [MAX_POINTS];
   logic [COL_W-1:0]  cell_col   [MAX_POINTS];
   cell_op_type       cell_op    [MAX_POINTS];
   logic [MAX_POINTS-1:0] cell_above;

   // Search results
   logic [IDX_W-1:0]  hi, lo;
   logic [POS_W-1:0]  l_pos, r_pos, rd_pos;
   logic [COL_W-1:0]  l_col, r_col, rd_col;
   logic              degen;
   logic              idx_valid, add_ok, rm_ok;
   logic [CNT_W-1:0]  count_m1;

   // Interpolation operands
   logic [POS_W-1:0]  pl_ff, pr_ff;
   logic [COL_W-1:0]  cl_ff, cr_ff;
   logic              degen_ff;
   logic [POS_W-1:0]  d_ff, sd_ff, s_ff;
   logic [POS_W-1:0]  clamped;
   logic [STEP_W-1:0] step_ff;
   lerp_ctrl_type     lerp_ctrl;
   logic [CH_W-1:0]   quo [4];

   // Result fields
   logic [COL_W-1:0]  res_col_ff;
   logic [POS_W-1:0]  res_pos_ff;
   logic [IDX_W-1:0]  res_idx_ff;
   logic              res_ok_ff;
   logic [COL_W-1:0]  out_col;

   logic              rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic              accept, out_free, load_rsp;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign load_rsp = (state_ff == ST_FINISH) && out_free;

   // Build the row of cells
   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      logic [POS_W-1:0] lp, rp;
      logic [COL_W-1:0] lc, rc;
      if (i == 0) begin : g_first
         assign lp = '0;
         assign lc = '0;
      end else begin : g_mid_l
         assign lp = cell_pos[i-1];
         assign lc = cell_col[i-1];
      end
      if (i == MAX_POINTS - 1) begin : g_last
         assign rp = '0;
         assign rc = '0;
      end else begin : g_mid_r
         assign rp = cell_pos[i+1];
         assign rc = cell_col[i+1];
      end
      plct_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .init_pos_val (init_pos(i)),
         .init_col_val (init_col(i)),
         .op           (cell_op[i]),
         .left_pos     (lp),
         .left_col     (lc),
         .right_pos    (rp),
         .right_col    (rc),
         .new_pos      (pos_ff),
         .new_col      (col_ff),
         .probe        (pos_ff),
         .pos_q        (cell_pos[i]),
         .col_q        (cell_col[i]),
         .above        (cell_above[i])
      );
   end

   // Four channel interpolators, red in the top byte of the color
   for (genvar c = 0; c < 4; c++) begin : g_lerp
      plct_lerp u_lerp (
         .clock    (clock),
         .ctrl     (lerp_ctrl),
         .left_ch  (cl_ff[COL_W-1-c*CH_W -: CH_W]),
         .right_ch (cr_ff[COL_W-1-c*CH_W -: CH_W]),
         .delta    (d_ff),
         .rest     (sd_ff),
         .span     (s_ff),
         .result   (quo[c])
      );
   end

   // Locate the first point above the probe and pick its neighbors
   always_comb begin
      count_m1  = count_ff - CNT_W'(1);
      hi        = count_m1[IDX_W-1:0];
      for (int i = MAX_POINTS - 1; i >= 0; i--) begin
         if (gt_ff[i]) begin
            hi = IDX_W'(i);
         end
      end
      lo     = hi - IDX_W'(1);
      l_pos  = '0;
      l_col  = '0;
      r_pos  = '0;
      r_col  = '0;
      rd_pos = '0;
      rd_col = '0;
      for (int i = 0; i < MAX_POINTS; i++) begin
         if (hi == IDX_W'(i)) begin
            r_pos = r_pos | cell_pos[i];
            r_col = r_col | cell_col[i];
         end
         if (hi != '0 && lo == IDX_W'(i)) begin
            l_pos = l_pos | cell_pos[i];
            l_col = l_col | cell_col[i];
         end
         if (idx_ff == IDX_W'(i)) begin
            rd_pos = rd_pos | cell_pos[i];
            rd_col = rd_col | cell_col[i];
         end
      end
      if (hi == '0) begin
         l_col = cell_col[0];
      end
      degen     = (hi == '0) || (r_pos <= l_pos);
      idx_valid = ({1'b0, idx_ff} < count_ff);
      add_ok    = (count_ff < CNT_W'(MAX_POINTS));
      rm_ok     = (idx_ff != '0) && ({1'b0, idx_ff} < count_m1);
   end

   // Clamp the probe into the segment
   always_comb begin
      if (pos_ff < pl_ff) begin
         clamped = pl_ff;
      end else if (pos_ff > pr_ff) begin
         clamped = pr_ff;
      end else begin
         clamped = pos_ff;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_FLAGS;
         ST_FLAGS:  state_in = ST_LOCATE;
         ST_LOCATE: state_in = (cmd_ff == CMD_SAMPLE) ? ST_PREP : ST_FINISH;
         ST_PREP:   state_in = ST_MULT;
         ST_MULT:   state_in = ST_INIT;
         ST_INIT:   state_in = ST_DIVIDE;
         ST_DIVIDE: if (step_ff == {STEP_W{1'b1}}) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State outputs: handshake, cell operations, divider control
   always_comb begin
      req_tready     = (state_ff == ST_IDLE);
      lerp_ctrl.mul  = (state_ff == ST_MULT);
      lerp_ctrl.init = (state_ff == ST_INIT);
      lerp_ctrl.step = (state_ff == ST_DIVIDE);
      for (int i = 0; i < MAX_POINTS; i++) begin
         cell_op[i] = OP_HOLD;
         if (state_ff == ST_LOCATE) begin
            case (cmd_ff)
               CMD_ADD: begin
                  if (add_ok) begin
                     if (hi == IDX_W'(i)) begin
                        cell_op[i] = OP_WRITE_BOTH;
                     end else if (IDX_W'(i) > hi && CNT_W'(i) <= count_ff) begin
                        cell_op[i] = OP_FROM_LEFT;
                     end
                  end
               end
               CMD_REMOVE: begin
                  if (rm_ok) begin
                     if (CNT_W'(i) == count_m1) begin
                        cell_op[i] = OP_CLEAR;
                     end else if (IDX_W'(i) >= idx_ff && CNT_W'(i) < count_m1) begin
                        cell_op[i] = OP_FROM_RIGHT;
                     end
                  end
               end
               CMD_SET_POS: begin
                  if (idx_valid && idx_ff == IDX_W'(i)) cell_op[i] = OP_WRITE_POS;
               end
               CMD_SET_COL: begin
                  if (idx_valid && idx_ff == IDX_W'(i)) cell_op[i] = OP_WRITE_COL;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= CNT_W'(2);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_LOCATE) begin
            if (cmd_ff == CMD_ADD && add_ok) begin
               count_ff <= count_ff + CNT_W'(1);
            end else if (cmd_ff == CMD_REMOVE && rm_ok) begin
               count_ff <= count_m1;
            end
         end
         if (load_rsp) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      // Latch the command word
      if (accept) begin
         cmd_ff <= req_tuser[2:0];
         pos_ff <= req_tdata[15:0];
         idx_ff <= req_tdata[19:16];
         col_ff <= {req_tdata[27:20], req_tdata[35:28], req_tdata[43:36], req_tdata[51:44]};
      end
      // Register the compare flags of live points
      if (state_ff == ST_FLAGS) begin
         for (int i = 0; i < MAX_POINTS; i++) begin
            gt_ff[i] <= cell_above[i] && (CNT_W'(i) < count_ff);
         end
      end
      // Capture segment ends and the command's result fields
      if (state_ff == ST_LOCATE) begin
         pl_ff      <= l_pos;
         pr_ff      <= r_pos;
         cl_ff      <= l_col;
         cr_ff      <= r_col;
         degen_ff   <= degen;
         res_col_ff <= '0;
         res_pos_ff <= '0;
         res_idx_ff <= '0;
         res_ok_ff  <= 1'b0;
         case (cmd_ff)
            CMD_SAMPLE:  res_ok_ff <= 1'b1;
            CMD_ADD: begin
               if (add_ok) begin
                  res_idx_ff <= hi;
                  res_ok_ff  <= 1'b1;
               end
            end
            CMD_REMOVE:  res_ok_ff <= rm_ok;
            CMD_SET_POS: res_ok_ff <= idx_valid;
            CMD_SET_COL: res_ok_ff <= idx_valid;
            CMD_READ: begin
               if (idx_valid) begin
                  res_col_ff <= rd_col;
                  res_pos_ff <= rd_pos;
                  res_ok_ff  <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      // Offset and span; a flat segment falls back to the left color
      if (state_ff == ST_PREP) begin
         if (degen_ff) begin
            d_ff  <= '0;
            sd_ff <= POS_W'(1);
            s_ff  <= POS_W'(1);
         end else begin
            d_ff  <= clamped - pl_ff;
            sd_ff <= pr_ff - clamped;
            s_ff  <= pr_ff - pl_ff;
         end
      end
      // Count division steps
      if (state_ff == ST_INIT) begin
         step_ff <= '0;
      end else if (state_ff == ST_DIVIDE) begin
         step_ff <= step_ff + STEP_W'(1);
      end
      // Load the output word
      if (load_rsp) begin
         rsp_tdata_ff <= {6'b0, count_ff, res_ok_ff, res_idx_ff, res_pos_ff,
                          out_col[CH_W-1:0], out_col[2*CH_W-1:CH_W],
                          out_col[3*CH_W-1:2*CH_W], out_col[COL_W-1:3*CH_W]};
      end
   end

   assign out_col = (cmd_ff == CMD_SAMPLE) ? {quo[0], quo[1], quo[2], quo[3]} : res_col_ff;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

@@ hdl/plct_cell.sv @@
`default_nettype none

module plct_cell
   import plct_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [POS_W-1:0]  init_pos_val,
   input  wire logic [COL_W-1:0]  init_col_val,
   input  wire cell_op_type       op,
   input  wire logic [POS_W-1:0]  left_pos,
   input  wire logic [COL_W-1:0]  left_col,
   input  wire logic [POS_W-1:0]  right_pos,
   input  wire logic [COL_W-1:0]  right_col,
   input  wire logic [POS_W-1:0]  new_pos,
   input  wire logic [COL_W-1:0]  new_col,
   input  wire logic [POS_W-1:0]  probe,
   output logic      [POS_W-1:0]  pos_q,
   output logic      [COL_W-1:0]  col_q,
   output logic                   above
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [COL_W-1:0] col_ff, col_in;

   // Pick the next contents: keep, take a neighbor's, take the new word, or clear
   always_comb begin
      pos_in = pos_ff;
      col_in = col_ff;
      case (op)
         OP_HOLD: begin
         end
         OP_FROM_LEFT: begin
            pos_in = left_pos;
            col_in = left_col;
         end
         OP_FROM_RIGHT: begin
            pos_in = right_pos;
            col_in = right_col;
         end
         OP_WRITE_POS: begin
            pos_in = new_pos;
         end
         OP_WRITE_COL: begin
            col_in = new_col;
         end
         OP_WRITE_BOTH: begin
            pos_in = new_pos;
            col_in = new_col;
         end
         OP_CLEAR: begin
            pos_in = '0;
            col_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= init_pos_val;
         col_ff <= init_col_val;
      end else begin
         pos_ff <= pos_in;
         col_ff <= col_in;
      end
   end

   assign pos_q = pos_ff;
   assign col_q = col_ff;
   assign above = (pos_ff > probe);

endmodule

`default_nettype wire

@@ hdl/plct_lerp.sv @@
`default_nettype none

module plct_lerp
   import plct_pkg::*;
(
   input  wire logic              clock,
   input  wire lerp_ctrl_type     ctrl,
   input  wire logic [CH_W-1:0]   left_ch,
   input  wire logic [CH_W-1:0]   right_ch,
   input  wire logic [POS_W-1:0]  delta,
   input  wire logic [POS_W-1:0]  rest,
   input  wire logic [POS_W-1:0]  span,
   output logic      [CH_W-1:0]   result
);

   logic [NUM_W-1:0] num_ff;
   logic [REM_W-1:0] rem_ff;
   logic [REM_W-1:0] div_ff;
   logic [CH_W-1:0]  quo_ff;
   logic [NUM_W-1:0] prod_l, prod_r;
   logic             fits;

   assign prod_l = NUM_W'(left_ch) * NUM_W'(rest);
   assign prod_r = NUM_W'(right_ch) * NUM_W'(delta);
   assign fits   = (rem_ff >= div_ff);

   // Weighted sum, then restoring division of (2*num + span) by 2*span, one bit a cycle
   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         num_ff <= prod_l + prod_r;
      end
      if (ctrl.init) begin
         rem_ff <= {num_ff, 1'b0} + REM_W'(span);
         div_ff <= REM_W'({span, 1'b0, {(CH_W-1){1'b0}}});
         quo_ff <= '0;
      end else if (ctrl.step) begin
         if (fits) begin
            rem_ff <= rem_ff - div_ff;
         end
         quo_ff <= {quo_ff[CH_W-2:0], fits};
         div_ff <= div_ff >> 1;
      end
   end

   assign result = quo_ff;

endmodule

`default_nettype wire

@@ hdl/plct_checker.sv @@
`default_nettype none

module plct_checker
   import plct_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   input  wire logic                    req_tready,
   input  wire logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire logic [RSP_TDATA_W-1:0]  rsp_tdata
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // Point count stays within two and the table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[57:53] >= 5'd2 && rsp_tdata[57:53] <= 5'(MAX_POINTS))
      else $error("point count out of range");

   // A refused command returns an all-zero payload
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[52] |-> rsp_tdata[51:0] == '0)
      else $error("refused command returned data");

   // Insert index lies inside the table
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> {1'b0, rsp_tdata[51:48]} < rsp_tdata[57:53])
      else $error("index beyond point count");

   // One word at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while busy");

endmodule

bind piecewise_linear_color_transfer plct_checker u_checker (.*);

`default_nettype wire
